### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, reported through $error.
`define WKP_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication check, reported through $error.
`define WKP_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/wkp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product package
// Shared types, register codes, fixed-point constants and the wavelet
// sample function used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package wkp_pkg;

  typedef enum logic [1:0] {
    REG_OFFSET        = 2'd0,
    REG_INVERSE_SCALE = 2'd1,
    REG_SCALE_ENABLED = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_EXP_M1  = 64'd395007542;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518851;
  localparam logic signed [17:0] Q16_ONE = 18'sd65536;
  localparam int HMAX = 4095;

  typedef struct packed {
    logic load;
    logic prod;
    logic index;
    logic rom;
    logic mul;
    logic round;
    logic second;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    logic last;
    logic out_free;
  } dp_status_t;

  // term i of the exp series divides by i
  function automatic logic [63:0] exp_step_div(input logic [63:0] x, input int i);
    case (i)
      2:       return x / 64'd2;
      3:       return x / 64'd3;
      4:       return x / 64'd4;
      5:       return x / 64'd5;
      6:       return x / 64'd6;
      7:       return x / 64'd7;
      8:       return x / 64'd8;
      9:       return x / 64'd9;
      10:      return x / 64'd10;
      11:      return x / 64'd11;
      12:      return x / 64'd12;
      13:      return x / 64'd13;
      default: return x;
    endcase
  endfunction

  // term i of the cos series divides by (2i-1)*2i
  function automatic logic [63:0] cos_step_div(input logic [63:0] x, input int i);
    case (i)
      1:       return x / 64'd2;
      2:       return x / 64'd12;
      3:       return x / 64'd30;
      4:       return x / 64'd56;
      5:       return x / 64'd90;
      6:       return x / 64'd132;
      7:       return x / 64'd182;
      8:       return x / 64'd240;
      9:       return x / 64'd306;
      10:      return x / 64'd380;
      default: return x;
    endcase
  endfunction

  // psi(t) = cos(1.75 t) * exp(-u), t in Q4.30, u = t*t/2 in Q.30
  function automatic logic signed [17:0] psi_entry(input logic [63:0] t,
                                                   input logic [63:0] u);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic signed [63:0] es;
    logic [63:0] e;
    logic [63:0] a;
    logic [63:0] a2;
    logic signed [63:0] cs;
    logic [63:0] c;
    logic [63:0] mag;
    logic [63:0] q;
    logic neg;
    if (t >= 64'd6 * Q30_ONE) begin
      return 18'sd0;
    end
    n = u >> 30;
    f = u & (Q30_ONE - 64'd1);
    term = Q30_ONE;
    es = $signed(Q30_ONE);
    for (int i = 1; i <= 13; i++) begin
      term = exp_step_div((term * f) >> 30, i);
      if ((i % 2) == 1) es = es - $signed(term);
      else es = es + $signed(term);
    end
    e = (es > 0) ? 64'(es) : 64'd0;
    for (int j = 0; j < 64; j++) begin
      if (64'(j) < n) e = (e * Q30_EXP_M1) >> 30;
    end
    a = (t * 64'd7) / 64'd4;
    a = a % Q30_TWO_PI;
    if (a > Q30_PI) a = Q30_TWO_PI - a;
    neg = 1'b0;
    if (a > Q30_HALF_PI) begin
      a = Q30_PI - a;
      neg = 1'b1;
    end
    a2 = (a * a) >> 30;
    term = Q30_ONE;
    cs = $signed(Q30_ONE);
    for (int i = 1; i <= 10; i++) begin
      term = cos_step_div((term * a2) >> 30, i);
      if ((i % 2) == 1) cs = cs - $signed(term);
      else cs = cs + $signed(term);
    end
    c = (cs > 0) ? 64'(cs) : 64'd0;
    mag = (c * e) >> 30;
    q = (mag + 64'd8192) >> 14;
    return neg ? -$signed(q[17:0]) : $signed(q[17:0]);
  endfunction

endpackage

### design/wkp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product controller
// Sequences the shared datapath through both elements of a pair when scaling
// is enabled, and on a last pair hands the product to the output register.
// ----------------------------------------------------------------------------
module wkp_ctrl
  import wkp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PROD   = 7'b0000010,
    S_INDEX  = 7'b0000100,
    S_ROM    = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_ROUND  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   second;
  logic   second_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd         = '0;
    cmd.second  = second;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          second_next = 1'b0;
          state_next  = status.enabled ? S_PROD : S_FINISH;
        end
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_INDEX;
      end
      S_INDEX: begin
        cmd.index  = 1'b1;
        state_next = S_ROM;
      end
      S_ROM: begin
        cmd.rom    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (second) begin
          state_next = S_FINISH;
        end else begin
          second_next = 1'b1;
          state_next  = S_PROD;
        end
      end
      S_FINISH: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule

### design/wkp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product datapath
// Scaled-offset multiply, index rounding, wavelet table, running product
// multiply with rounding, and the output register.
// ----------------------------------------------------------------------------
module wkp_datapath
  import wkp_pkg::*;
#(
  parameter int FUNC_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic signed [15:0] in_first,
  input  logic signed [15:0] in_second,
  input  logic               in_last,
  input  logic signed [15:0] offset,
  input  logic signed [15:0] inverse_scale,
  input  logic               scale_enabled,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_data
);

  localparam int IDX_W = $clog2(FUNC_TABLE_DEPTH);
  localparam logic [63:0] DEPTH64  = 64'(FUNC_TABLE_DEPTH);
  localparam logic [63:0] DEPTH_SQ = 64'(FUNC_TABLE_DEPTH) * 64'(FUNC_TABLE_DEPTH);

  typedef logic signed [17:0] rom_t [FUNC_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] kk;
    logic [63:0] t;
    logic [63:0] u;
    for (int k = 0; k < FUNC_TABLE_DEPTH; k++) begin
      kk = 64'(k) * 64'(k);
      t = (64'(k) << 34) / DEPTH64;
      u = (kk << 37) / DEPTH_SQ;
      rom[k] = psi_entry(t, u);
    end
    return rom;
  endfunction

  localparam rom_t PSI_ROM = build_rom();

  logic signed [15:0] a_reg;
  logic signed [15:0] b_reg;
  logic               last_reg;
  logic signed [32:0] p_reg;
  logic [IDX_W-1:0]   idx_reg;
  logic signed [17:0] psi_reg;
  logic signed [35:0] s_reg;
  logic signed [17:0] product;

  logic signed [15:0] x;
  logic signed [16:0] d;
  logic [32:0]        p_mag;
  logic [32:0]        h_full;
  logic [11:0]        h;
  logic [31:0]        idx_full;
  logic [IDX_W-1:0]   idx_next;
  logic [35:0]        s_mag;
  logic [35:0]        r;
  logic signed [17:0] round_next;

  assign x = cmd.second ? b_reg : a_reg;
  assign d = 17'(x) - 17'(offset);

  assign p_mag  = p_reg[32] ? 33'(-p_reg) : 33'(p_reg);
  assign h_full = (p_mag + 33'd128) >> 8;
  assign h      = (h_full > 33'(HMAX)) ? 12'(HMAX) : h_full[11:0];
  assign idx_full = ({20'd0, h} * 32'(FUNC_TABLE_DEPTH)) >> 12;
  assign idx_next = (idx_full >= 32'(FUNC_TABLE_DEPTH)) ? IDX_W'(FUNC_TABLE_DEPTH - 1)
                                                        : idx_full[IDX_W-1:0];

  // round half away from zero at bit 16
  assign s_mag = s_reg[35] ? 36'(-s_reg) : 36'(s_reg);
  assign r     = (s_mag + 36'd32768) >> 16;
  assign round_next = s_reg[35] ? -$signed(r[17:0]) : $signed(r[17:0]);

  assign status.enabled  = scale_enabled;
  assign status.last     = last_reg;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg    <= in_first;
      b_reg    <= in_second;
      last_reg <= in_last;
    end
    if (cmd.prod)  p_reg   <= 33'(d) * 33'(inverse_scale);
    if (cmd.index) idx_reg <= idx_next;
    if (cmd.rom)   psi_reg <= PSI_ROM[idx_reg];
    if (cmd.mul)   s_reg   <= 36'(product) * 36'(psi_reg);
    if (cmd.emit)  out_data <= product;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product   <= Q16_ONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.round) product <= round_next;
      else if (cmd.emit) product <= Q16_ONE;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### design/wavelet_kernel_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product
// Multiplies wavelet factors psi(a) * psi(b) of element pairs into a
// running Q1.16 product, emitted on the last pair of each vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one element pair per request, s_tlast marks the last
//   pair. Output stream m_*: one kernel value per vector.
//   APB port sets offset (0x0), inverse_scale (0x4), scale_enabled (0x8);
//   write it only while the block is idle.
// Sequencing:
//   With scale_enabled set the datapath and the synchronous wavelet table
//   are stepped through five stages for each of the two elements. With it
//   clear a pair goes from its load straight to the final step.
//   The result is registered and shows on m_tvalid in the cycle after the emit.
// Reset:
//   Synchronous; the running product returns to 1.0, APB registers clear to 0.
// Stall:
//   A held result does not block the next pairs; only a new last pair
//   waits in its final step until the output register is taken.
// ----------------------------------------------------------------------------
module wavelet_kernel_product
  import wkp_pkg::*;
#(
  parameter int FUNC_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] first_value, [31:16] second_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] kernel_value, [23:18] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [15:0] offset;
  logic signed [15:0] inverse_scale;
  logic               scale_enabled;
  logic signed [17:0] kernel_value;
  reg_index_t         reg_sel;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset        <= '0;
      inverse_scale <= '0;
      scale_enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_OFFSET:        offset        <= pwdata[15:0];
        REG_INVERSE_SCALE: inverse_scale <= pwdata[15:0];
        REG_SCALE_ENABLED: scale_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OFFSET:        prdata = {{16{offset[15]}}, offset};
      REG_INVERSE_SCALE: prdata = {{16{inverse_scale[15]}}, inverse_scale};
      REG_SCALE_ENABLED: prdata = {31'd0, scale_enabled};
      default:           prdata = '0;
    endcase
  end

  wkp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wkp_datapath #(
    .FUNC_TABLE_DEPTH (FUNC_TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_first      (s_tdata[15:0]),
    .in_second     (s_tdata[31:16]),
    .in_last       (s_tlast),
    .offset        (offset),
    .inverse_scale (inverse_scale),
    .scale_enabled (scale_enabled),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (kernel_value)
  );

  assign m_tdata = {6'd0, kernel_value};

endmodule

### design/wkp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product checker
// Port-level checks on the stream sides, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wkp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // hold a stalled result
  `WKP_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // a product of factors within one never leaves -1.0 .. 1.0
  `WKP_IMP(a_out_range, clk, rst, m_tvalid, (m_tdata[23:18] == 6'd0) && (m_tdata[17] ? m_tdata[16] : (!m_tdata[16] || (m_tdata[15:0] == 16'd0))))

  // an accepted request keeps the sequencer busy for the next cycle
  `WKP_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind wavelet_kernel_product wkp_checker u_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavelet kernel product testbench
// Streams element pairs through the block under changing register settings,
// predicts each kernel value from an independent wavelet table and product
// model, and checks every emitted value against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import wkp_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic               last_element;
  } pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wavelet_kernel_product #(.FUNC_TABLE_DEPTH(DEPTH)) DUT (.*);

  always #5 clk = ~clk;

  logic signed [17:0] wave_table [DEPTH];
  logic signed [15:0] cfg_offset = 0;
  logic signed [15:0] cfg_inv_scale = 0;
  logic               cfg_enabled = 0;
  logic signed [17:0] product_acc = Q16_ONE;

  pair_t              pending_pairs[$];
  logic signed [17:0] kernel_expected[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic logic signed [17:0] wave_sample(int k);
    logic [63:0] t, u, n, f, term, e, a, a2, c, mag, q;
    logic signed [63:0] es, cs;
    logic neg;
    t = (64'(k) << 34) / DEPTH;
    if (t >= 64'd6 * 64'd1073741824) return 0;
    u = ((64'(k) * 64'(k)) << 37) / (DEPTH * DEPTH);
    n = u >> 30;
    f = u & 64'h3FFF_FFFF;
    term = 64'd1073741824;
    es = 64'sd1073741824;
    for (int i = 1; i <= 13; i++) begin
      term = ((term * f) >> 30) / 64'(i);
      es = (i % 2) ? es - $signed(term) : es + $signed(term);
    end
    e = (es > 0) ? 64'(es) : 64'd0;
    for (longint j = 0; j < n; j++) e = (e * 64'd395007542) >> 30;
    a = ((t * 64'd7) / 64'd4) % 64'd6746518851;
    if (a > 64'd3373259426) a = 64'd6746518851 - a;
    neg = 0;
    if (a > 64'd1686629713) begin
      a = 64'd3373259426 - a;
      neg = 1;
    end
    a2 = (a * a) >> 30;
    term = 64'd1073741824;
    cs = 64'sd1073741824;
    for (int i = 1; i <= 10; i++) begin
      term = ((term * a2) >> 30) / 64'((2 * i - 1) * (2 * i));
      cs = (i % 2) ? cs - $signed(term) : cs + $signed(term);
    end
    c = (cs > 0) ? 64'(cs) : 64'd0;
    mag = (c * e) >> 30;
    q = (mag + 64'd8192) >> 14;
    return neg ? -$signed(q[17:0]) : $signed(q[17:0]);
  endfunction

  function automatic logic signed [17:0] wave_of(logic signed [15:0] x);
    longint p, m, h, idx;
    p = (longint'(x) - longint'(cfg_offset)) * longint'(cfg_inv_scale);
    m = (p < 0) ? -p : p;
    h = (m + 128) >>> 8;
    if (h > 4095) h = 4095;
    idx = (h * DEPTH) >>> 12;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return wave_table[idx];
  endfunction

  function automatic logic signed [17:0] q16_mul(logic signed [17:0] a, logic signed [17:0] b);
    longint s, m, r;
    s = longint'(a) * longint'(b);
    m = (s < 0) ? -s : s;
    r = (m + 32768) >>> 16;
    return 18'((s < 0) ? -r : r);
  endfunction

  // Update the running product for one accepted request.
  task automatic predict_pair(pair_t pr);
    if (cfg_enabled) begin
      product_acc = q16_mul(product_acc, wave_of(pr.first_value));
      product_acc = q16_mul(product_acc, wave_of(pr.second_value));
    end
    if (pr.last_element) begin
      kernel_expected.push_back(product_acc);
      product_acc = Q16_ONE;
    end
  endtask

  // Driver: feed pending pairs with random bursts of idling.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_pair(pending_pairs.pop_front());
      if (s_tvalid && !s_tready) begin
        // hold the request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 7);
        s_tvalid <= 1'b0;
      end else if (pending_pairs.size() > ((s_tvalid && s_tready) ? 0 : 0) &&
                   !(s_tvalid && s_tready && pending_pairs.size() == 0)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_pairs[0].second_value, pending_pairs[0].first_value};
        s_tlast <= pending_pairs[0].last_element;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls on the result side, compare with oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (kernel_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected kernel value %0d", $signed(m_tdata[17:0]));
        end else begin
          if (m_tdata[17:0] !== kernel_expected[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("kernel mismatch: expected %0d actual %0d",
                       kernel_expected[0], $signed(m_tdata[17:0]));
          end
          void'(kernel_expected.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OFFSET:        cfg_offset = value[15:0];
      REG_INVERSE_SCALE: cfg_inv_scale = value[15:0];
      REG_SCALE_ENABLED: cfg_enabled = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_tvalid || kernel_expected.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_pair(logic [15:0] a, logic [15:0] b, logic last);
    pair_t pr;
    pr.first_value = a;
    pr.second_value = b;
    pr.last_element = last;
    pending_pairs.push_back(pr);
  endtask

  // Mostly small magnitudes so psi stays nonzero; some full-range values.
  function automatic logic [15:0] rand_elem();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($signed(10'($urandom())));
  endfunction

  task automatic random_vectors(int count);
    int len;
    while (count > 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        add_pair(rand_elem(), rand_elem(), (i == len - 1) || ($urandom_range(0, 15) == 0));
      count -= len;
    end
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) wave_table[k] = wave_sample(k);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Disabled scale: factors skipped, product stays at one.
    add_pair(16'h7FFF, 16'h8000, 1'b1);
    add_pair(16'h0000, 16'hFFFF, 1'b0);
    add_pair(16'h1234, 16'h0100, 1'b1);
    drain();
    reg_write(REG_OFFSET, 32'h0000_0000);
    reg_write(REG_INVERSE_SCALE, 32'h0000_0100);
    reg_write(REG_SCALE_ENABLED, 32'h1);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_pair(16'h0000, 16'h0000, 1'b1);
    add_pair(16'h7FFF, 16'h8000, 1'b1);
    add_pair(16'h0080, 16'hFF80, 1'b0);
    add_pair(16'h0200, 16'hFE00, 1'b0);
    add_pair(16'h0040, 16'h00C0, 1'b1);
    add_pair(16'h0380, 16'h0100, 1'b1);
    drain();
    reg_write(REG_INVERSE_SCALE, 32'h0000_7FFF);
    reg_write(REG_OFFSET, 32'h0000_8000);
    add_pair(16'h8000, 16'h8001, 1'b1);
    add_pair(16'h7FFF, 16'h0000, 1'b1);
    drain();
    reg_write(REG_INVERSE_SCALE, 32'hFFFF_8000);
    reg_write(REG_OFFSET, 32'h0000_7FFF);
    add_pair(16'h7FFF, 16'h7FFE, 1'b1);
    add_pair(16'h8000, 16'h7FFF, 1'b1);
    drain();
    for (int phase = 0; phase < 9; phase++) begin
      reg_write(REG_OFFSET, $urandom_range(0, 1) ? 32'($signed(9'($urandom()))) : $urandom());
      case (phase % 3)
        0: reg_write(REG_INVERSE_SCALE, 32'($signed(10'($urandom()))));
        1: reg_write(REG_INVERSE_SCALE, $urandom_range(0, 1) ? 32'h7FFF : 32'hFFFF_8000);
        default: reg_write(REG_INVERSE_SCALE, $urandom());
      endcase
      reg_write(REG_SCALE_ENABLED,
                (phase == 4) ? 32'h0 : {31'($urandom_range(0, 7)), 1'b1});
      if (phase == 8) quiet = 1;
      random_vectors(150);
      drain();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && kernel_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
